/* rtl/core/cbcq_pkg.sv */
// Shared types, codes and defaults for the cell buffer with change queue.
package cbcq_pkg;

    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 128;
    localparam int DEF_QUEUE_DEPTH = 1024;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int ROWS_CFG_W = 7;
    localparam int COLS_CFG_W = 8;

    localparam logic [CFG_IDX_W-1:0]  CFG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_COLS_IN_USE = 1'd1;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET      = 7'd64;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET      = 8'd128;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_POP   = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [5:0]  out_row;
        logic [6:0]  out_col;
        logic [15:0] out_value;
        logic        dropped;
    } t_out_item;

    typedef struct packed {
        logic init_wr;
        logic capture;
        logic cell_rd_in;
        logic q_rd;
        logic pop_take;
        logic set_wr;
        logic clr_start;
        logic clr_issue;
        logic out_load;
        logic out_mem;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic in_range;
        logic q_empty;
        logic clr_empty;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/cell_buffer_with_change_queue.sv */
// Top level: cell buffer with a FIFO of changed positions.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready   | i_in  (kind, row, col, value)
//   out     | output    | o_out_valid / i_out_ready | o_out (ok, out_row, out_col,
//           |           |                           |        out_value, dropped)
//   cfg     | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// Set and get read the cell; pop reads the queue, then the cell (one memory
// port each); rejected or empty requests skip to the finish. Clear walks rows*cols
// cells, one cell read each cycle with the compare and write pipelined behind.
// After reset a clearing pass zeroes all MAX_ROWS*MAX_COLS cells, one a cycle,
// with o_in_ready low. A stalled output holds the finishing state; the next
// transaction is accepted while a result waits in the output register.
module cell_buffer_with_change_queue #(
    parameter int MAX_ROWS    = cbcq_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = cbcq_pkg::DEF_MAX_COLS,
    parameter int QUEUE_DEPTH = cbcq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  cbcq_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cbcq_pkg::t_out_item               o_out,
    input  logic                              i_cfg_we,
    input  logic [cbcq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cbcq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    cbcq_pkg::t_cmd w_cmd;
    cbcq_pkg::t_sts w_sts;

    cbcq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in.kind),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    cbcq_dpath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* rtl/core/cbcq_ctrl.sv */
// Controller state machine: sequences init sweep, set, get, pop and clear.
module cbcq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_kind,
    input  cbcq_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output cbcq_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_SETW = 4'd2;
    localparam logic [3:0] ST_GETO = 4'd3;
    localparam logic [3:0] ST_POPA = 4'd4;
    localparam logic [3:0] ST_POPO = 4'd5;
    localparam logic [3:0] ST_CLR  = 4'd6;
    localparam logic [3:0] ST_CLRD = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_FIN;
                    case (i_kind)
                        cbcq_pkg::KIND_SET: begin
                            if (i_sts.in_range) begin
                                o_cmd.cell_rd_in = 1'b1;
                                n_state          = ST_SETW;
                            end
                        end
                        cbcq_pkg::KIND_GET: begin
                            if (i_sts.in_range) begin
                                o_cmd.cell_rd_in = 1'b1;
                                n_state          = ST_GETO;
                            end
                        end
                        cbcq_pkg::KIND_POP: begin
                            if (!i_sts.q_empty) begin
                                o_cmd.q_rd = 1'b1;
                                n_state    = ST_POPA;
                            end
                        end
                        default: begin
                            if (!i_sts.clr_empty) begin
                                o_cmd.clr_start = 1'b1;
                                n_state         = ST_CLR;
                            end
                        end
                    endcase
                end
            end
            ST_SETW: begin
                // write and report together once the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.set_wr   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_GETO: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_mem  = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_POPA: begin
                o_cmd.pop_take = 1'b1;
                n_state        = ST_POPO;
            end
            ST_POPO: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_mem  = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_CLR: begin
                o_cmd.clr_issue = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_CLRD;
                end
            end
            ST_CLRD: begin
                // last cell of the walk is compared and written here
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/cbcq_dpath.sv */
// Datapath: cell memory, change queue memory, pointers, walk counters, output register.
module cbcq_dpath #(
    parameter int MAX_ROWS    = cbcq_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = cbcq_pkg::DEF_MAX_COLS,
    parameter int QUEUE_DEPTH = cbcq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cbcq_pkg::t_cmd                    i_cmd,
    output cbcq_pkg::t_sts                    o_sts,
    input  cbcq_pkg::t_in_item                i_in,
    input  logic                              i_cfg_we,
    input  logic [cbcq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cbcq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cbcq_pkg::t_out_item               o_out
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int QCW   = QW + 1;
    localparam int EW    = RW + CW;

    // configuration
    logic [cbcq_pkg::ROWS_CFG_W-1:0] r_rows;
    logic [cbcq_pkg::COLS_CFG_W-1:0] r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= cbcq_pkg::ROWS_RESET;
            r_cols <= cbcq_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cbcq_pkg::CFG_ROWS_IN_USE: r_rows <= i_cfg_data[cbcq_pkg::ROWS_CFG_W-1:0];
                cbcq_pkg::CFG_COLS_IN_USE: r_cols <= i_cfg_data[cbcq_pkg::COLS_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective bounds, clamped to the physical store
    logic [8:0] w_nr;
    logic [8:0] w_nc;
    assign w_nr = (9'(r_rows) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(r_rows);
    assign w_nc = (9'(r_cols) > 9'(MAX_COLS)) ? 9'(MAX_COLS) : 9'(r_cols);

    // registers
    logic [AW-1:0]  r_init_addr;
    logic [15:0]    r_rd_data;
    logic [15:0]    r_value;
    logic [AW-1:0]  r_addr;
    logic [7:0]     r_res_row;
    logic [7:0]     r_res_col;
    logic           r_ok;
    logic           r_drop;
    logic [EW-1:0]  r_q_data;
    logic [QW-1:0]  r_head;
    logic [QW-1:0]  r_tail;
    logic [QCW-1:0] r_count;
    logic [RW-1:0]  r_ci;
    logic [CW-1:0]  r_cj;
    logic           r_pend;
    logic [AW-1:0]  r_pend_addr;
    logic [RW-1:0]  r_pend_row;
    logic [CW-1:0]  r_pend_col;
    logic           r_out_valid;
    cbcq_pkg::t_out_item r_out;

    logic [15:0] m_cells [0:CELLS-1];
    logic [EW-1:0] m_q [0:QUEUE_DEPTH-1];

    // address and decision logic
    logic          w_in_range;
    logic [AW-1:0] w_addr_in;
    logic [RW-1:0] w_q_row;
    logic [CW-1:0] w_q_col;
    logic [AW-1:0] w_addr_q;
    logic [AW-1:0] w_addr_clr;
    logic          w_chg;
    logic          w_clr_hit;
    logic          w_full;
    logic          w_enq;
    logic [EW-1:0] w_enq_data;
    logic          w_row_end;
    logic          w_col_end;
    logic          w_cw_en;
    logic [AW-1:0] w_cw_addr;
    logic [15:0]   w_cw_data;
    logic          w_cr_en;
    logic [AW-1:0] w_cr_addr;
    logic          w_out_free;

    assign w_in_range = (9'(i_in.row) < w_nr) && (9'(i_in.col) < w_nc);
    assign w_addr_in  = AW'(32'(i_in.row) * 32'(MAX_COLS) + 32'(i_in.col));
    assign w_q_row    = r_q_data[EW-1:CW];
    assign w_q_col    = r_q_data[CW-1:0];
    assign w_addr_q   = AW'(32'(w_q_row) * 32'(MAX_COLS) + 32'(w_q_col));
    assign w_addr_clr = AW'(32'(r_ci) * 32'(MAX_COLS) + 32'(r_cj));

    assign w_chg      = (r_rd_data != r_value);
    assign w_clr_hit  = r_pend && (r_rd_data != 16'd0);
    assign w_full     = (r_count == QCW'(QUEUE_DEPTH));
    assign w_enq      = (i_cmd.set_wr && w_chg) || w_clr_hit;
    assign w_enq_data = i_cmd.set_wr ? {r_res_row[RW-1:0], r_res_col[CW-1:0]}
                                     : {r_pend_row, r_pend_col};
    assign w_row_end  = (9'(r_ci) + 9'd1 == w_nr);
    assign w_col_end  = (9'(r_cj) + 9'd1 == w_nc);
    assign w_out_free = !r_out_valid || i_out_ready;

    // cell memory write port
    always_comb begin
        w_cw_en   = 1'b0;
        w_cw_addr = r_addr;
        w_cw_data = r_value;
        if (i_cmd.init_wr) begin
            w_cw_en   = 1'b1;
            w_cw_addr = r_init_addr;
            w_cw_data = 16'd0;
        end else if (i_cmd.set_wr) begin
            w_cw_en = w_chg;
        end else if (w_clr_hit) begin
            w_cw_en   = 1'b1;
            w_cw_addr = r_pend_addr;
            w_cw_data = 16'd0;
        end
    end

    // cell memory read port
    always_comb begin
        w_cr_en   = 1'b0;
        w_cr_addr = w_addr_clr;
        if (i_cmd.cell_rd_in) begin
            w_cr_en   = 1'b1;
            w_cr_addr = w_addr_in;
        end else if (i_cmd.pop_take) begin
            w_cr_en   = 1'b1;
            w_cr_addr = w_addr_q;
        end else if (i_cmd.clr_issue) begin
            w_cr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw_en) begin
            m_cells[w_cw_addr] <= w_cw_data;
        end
        if (w_cr_en) begin
            r_rd_data <= m_cells[w_cr_addr];
        end
    end

    // change queue memory
    always_ff @(posedge i_clk) begin
        if (w_enq && !w_full) begin
            m_q[r_tail] <= w_enq_data;
        end
        if (i_cmd.q_rd) begin
            r_q_data <= m_q[r_head];
        end
    end

    // control state: pointers, counters, sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_init_addr <= '0;
            r_pend      <= 1'b0;
            r_ci        <= '0;
            r_cj        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init_wr) begin
                r_init_addr <= r_init_addr + AW'(1);
            end
            if (w_enq && !w_full) begin
                r_tail  <= (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QW'(1);
                r_count <= r_count + QCW'(1);
            end else if (i_cmd.pop_take) begin
                r_head  <= (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QW'(1);
                r_count <= r_count - QCW'(1);
            end
            r_pend <= i_cmd.clr_issue;
            if (i_cmd.clr_start) begin
                r_ci <= '0;
                r_cj <= '0;
            end else if (i_cmd.clr_issue) begin
                if (w_col_end) begin
                    r_cj <= '0;
                    r_ci <= r_ci + RW'(1);
                end else begin
                    r_cj <= r_cj + CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction payload and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value   <= i_in.value;
            r_addr    <= w_addr_in;
            r_res_row <= i_in.row;
            r_res_col <= i_in.col;
            r_ok      <= (i_in.kind == cbcq_pkg::KIND_GET) && w_in_range;
            r_drop    <= 1'b0;
        end else if (i_cmd.pop_take) begin
            r_ok      <= 1'b1;
            r_res_row <= 8'(w_q_row);
            r_res_col <= 8'(w_q_col);
        end else if (w_clr_hit && w_full) begin
            r_drop <= 1'b1;
        end
        if (i_cmd.clr_issue) begin
            r_pend_addr <= w_addr_clr;
            r_pend_row  <= r_ci;
            r_pend_col  <= r_cj;
        end
        if (i_cmd.out_load) begin
            r_out.ok        <= i_cmd.set_wr ? w_chg : r_ok;
            r_out.out_row   <= r_res_row[5:0];
            r_out.out_col   <= r_res_col[6:0];
            r_out.out_value <= i_cmd.out_mem ? r_rd_data : 16'd0;
            r_out.dropped   <= i_cmd.set_wr ? (w_chg && w_full) : r_drop;
        end
    end

    assign o_sts.init_last = (r_init_addr == AW'(CELLS - 1));
    assign o_sts.in_range  = w_in_range;
    assign o_sts.q_empty   = (r_count == '0);
    assign o_sts.clr_empty = (w_nr == 9'd0) || (w_nc == 9'd0);
    assign o_sts.clr_last  = w_row_end && w_col_end;
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
